FILE: rtl/hcfd_pkg.sv
`timescale 1ns / 1ps

package hcfd_pkg;

    localparam int MAX_HASHES      = 1024;
    localparam int MAX_FRAME_BYTES = 32800;

    localparam int HDR_BYTES = 32;
    localparam int CNT_W     = 16;
    localparam int HDR_AW    = $clog2(HDR_BYTES);
    localparam int HASH_W    = $clog2(MAX_HASHES + 1);
    localparam int CFG_AW    = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] MAGIC_0 = 8'h52;
    localparam logic [7:0] MAGIC_1 = 8'h47;
    localparam logic [7:0] MAGIC_2 = 8'h41;
    localparam logic [7:0] MAGIC_3 = 8'h31;
    localparam logic [7:0] VERSION = 8'd1;

    localparam int VER_POS   = 4;
    localparam int KIND_POS  = 5;
    localparam int RES_POS   = 6;
    localparam int ID_POS    = 8;
    localparam int CHUNK_POS = 24;
    localparam int COUNT_POS = 28;

    typedef enum logic [CFG_AW-1:0] {
        CFG_KIND_INVENTORY = 2'd0,
        CFG_KIND_RESET     = 2'd1,
        CFG_KIND_ADD       = 2'd2,
        CFG_KIND_REMOVE    = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SMALL    = 4'd1,
        ST_LARGE    = 4'd2,
        ST_MAGIC    = 4'd3,
        ST_VERSION  = 4'd4,
        ST_KIND     = 4'd5,
        ST_RESERVED = 4'd6,
        ST_COUNT    = 4'd7,
        ST_SIZE     = 4'd8
    } status_t;

    typedef struct packed {
        logic [1:0]  kind_index;
        logic [63:0] transfer_id_high;
        logic [63:0] transfer_id_low;
        logic [31:0] chunk_number;
        logic [31:0] hash_count;
        status_t     status;
    } summary_t;

    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload_byte;
        logic       has_summary;
        summary_t   summary;
    } entry_t;

    typedef struct packed {
        logic       is_summary;
        logic [7:0] payload_byte;
        summary_t   summary;
        logic       last;
    } result_t;

endpackage

FILE: rtl/hcfd_front.sv
`timescale 1ns / 1ps

module hcfd_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       frame_end,
    input  logic                       cfg_write_en,
    input  logic [hcfd_pkg::CFG_AW-1:0] cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic                       q_full,
    output logic                       q_push,
    output hcfd_pkg::entry_t           q_entry
);
    import hcfd_pkg::*;

    logic [7:0]       kind_inv_reg;
    logic [7:0]       kind_rst_reg;
    logic [7:0]       kind_add_reg;
    logic [7:0]       kind_rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] len;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic [7:0]       hdr_view [HDR_BYTES];
    logic             in_hdr;
    logic             accept;
    logic [1:0]       kidx;
    logic             kind_ok;
    logic [31:0]      count;
    logic [31:0]      size_exp;
    summary_t         sum;
    status_t          st;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign in_hdr   = (cnt_reg < CNT_W'(HDR_BYTES));
    assign len      = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_inv_reg <= 8'd0;
            kind_rst_reg <= 8'd1;
            kind_add_reg <= 8'd2;
            kind_rem_reg <= 8'd3;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KIND_INVENTORY: kind_inv_reg <= cfg_data;
                CFG_KIND_RESET:     kind_rst_reg <= cfg_data;
                CFG_KIND_ADD:       kind_add_reg <= cfg_data;
                CFG_KIND_REMOVE:    kind_rem_reg <= cfg_data;
                default:            kind_inv_reg <= kind_inv_reg;
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = frame_end ? '0 : len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_hdr)
        begin
            hdr_reg[cnt_reg[HDR_AW-1:0]] <= data_byte;
        end
    end

    // fold in the byte being taken so a frame ending on the last header byte sees it
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_view[i] = (in_hdr && cnt_reg[HDR_AW-1:0] == HDR_AW'(i)) ? data_byte
                                                                          : hdr_reg[i];
        end
    end

    always_comb
    begin
        sum     = '0;
        kidx    = 2'd0;
        kind_ok = 1'b1;
        count   = {hdr_view[COUNT_POS], hdr_view[COUNT_POS+1],
                   hdr_view[COUNT_POS+2], hdr_view[COUNT_POS+3]};
        size_exp = {{(32-HASH_W-5){1'b0}}, count[HASH_W-1:0], 5'b0} + 32'(HDR_BYTES);

        if (hdr_view[KIND_POS] == kind_inv_reg)      kidx = 2'd0;
        else if (hdr_view[KIND_POS] == kind_rst_reg) kidx = 2'd1;
        else if (hdr_view[KIND_POS] == kind_add_reg) kidx = 2'd2;
        else if (hdr_view[KIND_POS] == kind_rem_reg) kidx = 2'd3;
        else                                         kind_ok = 1'b0;

        if (len < CNT_W'(HDR_BYTES))
            st = ST_SMALL;
        else if (len > CNT_W'(MAX_FRAME_BYTES))
            st = ST_LARGE;
        else if (hdr_view[0] != MAGIC_0 || hdr_view[1] != MAGIC_1 ||
                 hdr_view[2] != MAGIC_2 || hdr_view[3] != MAGIC_3)
            st = ST_MAGIC;
        else if (hdr_view[VER_POS] != VERSION)
            st = ST_VERSION;
        else if (!kind_ok)
            st = ST_KIND;
        else if (hdr_view[RES_POS] != 8'd0 || hdr_view[RES_POS+1] != 8'd0)
            st = ST_RESERVED;
        else if (count > 32'(MAX_HASHES))
            st = ST_COUNT;
        else if ({{(32-CNT_W){1'b0}}, len} != size_exp)
            st = ST_SIZE;
        else
            st = ST_OK;

        sum.status = st;
        if (st != ST_SMALL)
        begin
            sum.kind_index = kidx;
            for (int k = 0; k < 8; k++)
            begin
                sum.transfer_id_high[63-8*k -: 8] = hdr_view[ID_POS+k];
                sum.transfer_id_low[63-8*k -: 8]  = hdr_view[ID_POS+8+k];
            end
            sum.chunk_number = {hdr_view[CHUNK_POS], hdr_view[CHUNK_POS+1],
                                hdr_view[CHUNK_POS+2], hdr_view[CHUNK_POS+3]};
            sum.hash_count   = count;
        end
    end

    // drop header bytes that do not end the frame: they yield no result
    assign q_push               = accept && (!in_hdr || frame_end);
    assign q_entry.has_payload  = !in_hdr;
    assign q_entry.payload_byte = data_byte;
    assign q_entry.has_summary  = frame_end;
    assign q_entry.summary      = sum;

endmodule

FILE: rtl/hcfd_queue.sv
`timescale 1ns / 1ps

module hcfd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hcfd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output hcfd_pkg::entry_t head
);
    import hcfd_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/hcfd_back.sv
`timescale 1ns / 1ps

module hcfd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  hcfd_pkg::entry_t  q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output hcfd_pkg::result_t out_item
);
    import hcfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    pend_reg;
    logic    pend_next;
    result_t item_reg;
    result_t item_next;
    logic    load_ok;

    assign load_ok = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        item_next  = item_reg;
        q_pop      = 1'b0;
        if (load_ok)
        begin
            valid_next = 1'b0;
            if (!q_empty)
            begin
                valid_next = 1'b1;
                item_next  = '0;
                if (q_head.has_payload && !pend_reg)
                begin
                    // send payload first, hold the entry if a summary follows
                    item_next.payload_byte = q_head.payload_byte;
                    item_next.last         = !q_head.has_summary;
                    pend_next              = q_head.has_summary;
                    q_pop                  = !q_head.has_summary;
                end
                else
                begin
                    item_next.is_summary = 1'b1;
                    item_next.summary    = q_head.summary;
                    item_next.last       = 1'b1;
                    pend_next            = 1'b0;
                    q_pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/hash_chunk_frame_decoder.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------------
// in       | input     | in_valid / in_stall  | data_byte, frame_end
// out      | output    | out_valid / out_stall| is_summary, payload_byte, kind_index,
//          |           |                      | transfer_id_high/low, chunk_number,
//          |           |                      | hash_count, status, last
// cfg      | input     | cfg_write_en         | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each result leaves through the
// queue and the registered output stage. A payload byte that ends its frame yields
// two results, which the two-entry queue between the front and the output stage absorbs.
// Frame checks run in the cycle the final byte is taken.
// Reset clears the byte counter, the queue and the output stage; the header
// bytes are not cleared. in_stall rises while the queue is full.

module hash_chunk_frame_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        frame_end,
    input  logic                        cfg_write_en,
    input  logic [hcfd_pkg::CFG_AW-1:0] cfg_index,
    input  logic [7:0]                  cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_summary,
    output logic [7:0]                  payload_byte,
    output logic [1:0]                  kind_index,
    output logic [63:0]                 transfer_id_high,
    output logic [63:0]                 transfer_id_low,
    output logic [31:0]                 chunk_number,
    output logic [31:0]                 hash_count,
    output logic [3:0]                  status,
    output logic                        last
);
    import hcfd_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_empty;
    logic    q_pop;
    entry_t  q_in;
    entry_t  q_head;
    result_t item;

    hcfd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    hcfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    hcfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (item)
    );

    assign is_summary       = item.is_summary;
    assign payload_byte     = item.payload_byte;
    assign kind_index       = item.summary.kind_index;
    assign transfer_id_high = item.summary.transfer_id_high;
    assign transfer_id_low  = item.summary.transfer_id_low;
    assign chunk_number     = item.summary.chunk_number;
    assign hash_count       = item.summary.hash_count;
    assign status           = item.summary.status;
    assign last             = item.last;

endmodule
